// ----- rtl/core/ckb_pkg.sv -----
// ----------------------------------------------------------------------------
// ckb_pkg
// shared types, constants and helpers of the color key blitter
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int MAX_DIM   = 1024;
  localparam int PIX_W     = 16;
  localparam int DIM_W     = 11;
  localparam int CW        = 14;
  localparam int SXW       = 12;
  localparam int CNT_W     = 13;
  localparam int CFG_AW    = 5;

  localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(4096);

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_BLIT  = 2'd2;

  localparam logic [2:0] REG_SRC_BASE   = 3'd0;
  localparam logic [2:0] REG_SRC_STRIDE = 3'd1;
  localparam logic [2:0] REG_DST_BASE   = 3'd2;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd4;
  localparam logic [2:0] REG_KEY_COLOR  = 3'd5;
  localparam logic [2:0] REG_KEY_ENABLE = 3'd6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [PIX_W-1:0]  pix_t;

  function automatic dim_t sat_dim(input dim_t v);
    dim_t res;
    res = (32'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ckb_ram.sv -----
// ----------------------------------------------------------------------------
// ckb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/color_key_blitter_with_clipping.sv -----
// ----------------------------------------------------------------------------
// color_key_blitter_with_clipping
// pixel memory with host access and clipped, color keyed rectangle blit
// ----------------------------------------------------------------------------
//  channel  | ports                                    | handshake
//  input    | start, busy, in_kind .. in_rect_h        | accepted when start & !busy
//  result   | out_valid, out_read_data, out_pixels_... | one cycle strobe, no stall
//  config   | psel, penable, pwrite, paddr, pwdata ... | apb write, pready tied high
//
//  write item: busy stays low, result in the cycle after accept
//  read item: busy one cycle in S_READ, result registered from the ram read in S_READ
//  blit item: busy in S_CLIP (alone when fully clipped), S_BASE, S_RUN and S_DRAIN;
//  one clipped-rectangle pixel per cycle through the single read and write port
//  synchronous active low reset clears control and configuration registers, not the memory
// ----------------------------------------------------------------------------
`default_nettype none

module color_key_blitter_with_clipping (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [11:0]                in_addr,
  input  wire logic [15:0]                in_data,
  input  wire logic signed [10:0]         in_dst_x,
  input  wire logic signed [10:0]         in_dst_y,
  input  wire logic [9:0]                 in_src_x,
  input  wire logic [9:0]                 in_src_y,
  input  wire logic [10:0]                in_rect_w,
  input  wire logic [10:0]                in_rect_h,
  output logic                            out_valid,
  output logic [15:0]                     out_read_data,
  output logic [12:0]                     out_pixels_written,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ckb_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CLIP  = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  localparam int AW = ckb_pkg::ADDR_W;
  localparam int CW = ckb_pkg::CW;

  // configuration
  logic [11:0]          src_base_r;
  ckb_pkg::dim_t        src_stride_r;
  logic [11:0]          dst_base_r;
  ckb_pkg::dim_t        dst_width_r;
  ckb_pkg::dim_t        dst_height_r;
  ckb_pkg::pix_t        key_color_r;
  logic                 key_enable_r;
  logic                 cfg_wr;

  // control
  logic [2:0]           state_r, state_nxt;
  logic                 accept;

  // latched blit item
  logic signed [10:0]   dx_r, dy_r;
  logic [9:0]           sx_r, sy_r;
  ckb_pkg::dim_t        rw_r, rh_r;

  // clipped rectangle
  logic [ckb_pkg::SXW-1:0] sx1_r, sy1_r;
  ckb_pkg::dim_t        dx1_r, dy1_r;
  ckb_pkg::dim_t        bw_last_r, bh_last_r;
  logic signed [CW-1:0] dx_s, dy_s, bw0, bh0, dw_s, dh_s;
  logic signed [CW-1:0] sx1, sy1, dx1, dy1, bw1, bh1, bw2, bh2;
  logic                 clip_empty;

  // walk
  ckb_pkg::dim_t        stride_s, dw_sat;
  ckb_pkg::addr_t       s_row_r, d_row_r, s_ptr_r, d_ptr_r;
  ckb_pkg::addr_t       s_row_nxt, d_row_nxt;
  ckb_pkg::dim_t        cx_r, cy_r;
  logic                 row_end, blit_end;

  // pixel stage
  logic                 p_valid_r;
  ckb_pkg::addr_t       p_daddr_r;
  logic                 fwd_r;
  ckb_pkg::pix_t        fwd_data_r;
  ckb_pkg::pix_t        px;
  logic                 px_store;
  logic [ckb_pkg::CNT_W-1:0] count_r, count_nxt;

  // memory port
  logic                 ram_we;
  ckb_pkg::addr_t       ram_waddr, ram_raddr;
  ckb_pkg::pix_t        ram_wdata, ram_rdata;

  // result
  logic                 out_valid_r;
  ckb_pkg::pix_t        out_read_data_r;
  logic [ckb_pkg::CNT_W-1:0] out_pixels_r;

  ckb_ram #(
    .WIDTH (ckb_pkg::PIX_W),
    .DEPTH (ckb_pkg::MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r   <= '0;
      src_stride_r <= ckb_pkg::DIM_W'(64);
      dst_base_r   <= '0;
      dst_width_r  <= ckb_pkg::DIM_W'(64);
      dst_height_r <= ckb_pkg::DIM_W'(64);
      key_color_r  <= '0;
      key_enable_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ckb_pkg::REG_SRC_BASE:   src_base_r   <= pwdata[11:0];
        ckb_pkg::REG_SRC_STRIDE: src_stride_r <= pwdata[10:0];
        ckb_pkg::REG_DST_BASE:   dst_base_r   <= pwdata[11:0];
        ckb_pkg::REG_DST_WIDTH:  dst_width_r  <= pwdata[10:0];
        ckb_pkg::REG_DST_HEIGHT: dst_height_r <= pwdata[10:0];
        ckb_pkg::REG_KEY_COLOR:  key_color_r  <= pwdata[15:0];
        ckb_pkg::REG_KEY_ENABLE: key_enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      ckb_pkg::REG_SRC_BASE:   prdata = 32'(src_base_r);
      ckb_pkg::REG_SRC_STRIDE: prdata = 32'(src_stride_r);
      ckb_pkg::REG_DST_BASE:   prdata = 32'(dst_base_r);
      ckb_pkg::REG_DST_WIDTH:  prdata = 32'(dst_width_r);
      ckb_pkg::REG_DST_HEIGHT: prdata = 32'(dst_height_r);
      ckb_pkg::REG_KEY_COLOR:  prdata = 32'(key_color_r);
      ckb_pkg::REG_KEY_ENABLE: prdata = 32'(key_enable_r);
      default:                 prdata = '0;
    endcase
  end

  // clipping
  always_comb begin
    dx_s = CW'(dx_r);
    dy_s = CW'(dy_r);
    bw0  = CW'(ckb_pkg::sat_dim(rw_r));
    bh0  = CW'(ckb_pkg::sat_dim(rh_r));
    dw_s = CW'(ckb_pkg::sat_dim(dst_width_r));
    dh_s = CW'(ckb_pkg::sat_dim(dst_height_r));
    sx1  = CW'(sx_r);
    sy1  = CW'(sy_r);
    dx1  = dx_s;
    dy1  = dy_s;
    bw1  = bw0;
    bh1  = bh0;
    if (dx_s < 0) begin
      sx1 = CW'(sx_r) - dx_s;
      bw1 = bw0 + dx_s;
      dx1 = '0;
    end
    if (dy_s < 0) begin
      sy1 = CW'(sy_r) - dy_s;
      bh1 = bh0 + dy_s;
      dy1 = '0;
    end
    bw2 = (bw1 + dx1 > dw_s) ? dw_s - dx1 : bw1;
    bh2 = (bh1 + dy1 > dh_s) ? dh_s - dy1 : bh1;
    clip_empty = (bw2 <= 0) || (bh2 <= 0);
  end

  // walk addressing
  assign stride_s  = ckb_pkg::sat_dim(src_stride_r);
  assign dw_sat    = ckb_pkg::sat_dim(dst_width_r);
  assign s_row_nxt = s_row_r + AW'(stride_s);
  assign d_row_nxt = d_row_r + AW'(dw_sat);
  assign row_end   = (cx_r == bw_last_r);
  assign blit_end  = row_end && (cy_r == bh_last_r);

  // pixel stage with forwarding of the write in flight
  assign px       = fwd_r ? fwd_data_r : ram_rdata;
  assign px_store = p_valid_r && !(key_enable_r && (px == key_color_r));
  assign count_nxt = (px_store && (count_r != ckb_pkg::COUNT_SAT)) ?
                     count_r + 1'b1 : count_r;

  always_comb begin
    ram_we    = px_store;
    ram_waddr = p_daddr_r;
    ram_wdata = px;
    ram_raddr = s_ptr_r;
    if (state_r == S_IDLE) begin
      ram_we    = accept && (in_kind == ckb_pkg::KIND_WRITE);
      ram_waddr = AW'(in_addr);
      ram_wdata = in_data;
      ram_raddr = AW'(in_addr);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == ckb_pkg::KIND_READ) begin
            state_nxt = S_READ;
          end else if (in_kind == ckb_pkg::KIND_BLIT) begin
            state_nxt = S_CLIP;
          end
        end
      end
      S_READ:  state_nxt = S_IDLE;
      S_CLIP:  state_nxt = clip_empty ? S_IDLE : S_BASE;
      S_BASE:  state_nxt = S_RUN;
      S_RUN:   state_nxt = blit_end ? S_DRAIN : S_RUN;
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_valid_r   <= (state_r == S_RUN);
      fwd_r       <= ram_we && (ram_waddr == ram_raddr);
      out_valid_r <= (accept && (in_kind != ckb_pkg::KIND_READ) &&
                      (in_kind != ckb_pkg::KIND_BLIT)) ||
                     (state_r == S_READ) ||
                     ((state_r == S_CLIP) && clip_empty) ||
                     (state_r == S_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    p_daddr_r  <= d_ptr_r;
    if (accept) begin
      dx_r <= in_dst_x;
      dy_r <= in_dst_y;
      sx_r <= in_src_x;
      sy_r <= in_src_y;
      rw_r <= in_rect_w;
      rh_r <= in_rect_h;
    end
    if (state_r == S_CLIP) begin
      sx1_r     <= ckb_pkg::SXW'(sx1);
      sy1_r     <= ckb_pkg::SXW'(sy1);
      dx1_r     <= ckb_pkg::DIM_W'(dx1);
      dy1_r     <= ckb_pkg::DIM_W'(dy1);
      bw_last_r <= ckb_pkg::DIM_W'(bw2 - 1);
      bh_last_r <= ckb_pkg::DIM_W'(bh2 - 1);
    end
    if (state_r == S_BASE) begin
      s_row_r <= AW'(src_base_r) + AW'(sy1_r) * AW'(stride_s) + AW'(sx1_r);
      s_ptr_r <= AW'(src_base_r) + AW'(sy1_r) * AW'(stride_s) + AW'(sx1_r);
      d_row_r <= AW'(dst_base_r) + AW'(dy1_r) * AW'(dw_sat) + AW'(dx1_r);
      d_ptr_r <= AW'(dst_base_r) + AW'(dy1_r) * AW'(dw_sat) + AW'(dx1_r);
      cx_r    <= '0;
      cy_r    <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    if (state_r == S_RUN) begin
      if (row_end) begin
        cx_r    <= '0;
        cy_r    <= cy_r + 1'b1;
        s_row_r <= s_row_nxt;
        d_row_r <= d_row_nxt;
        s_ptr_r <= s_row_nxt;
        d_ptr_r <= d_row_nxt;
      end else begin
        cx_r    <= cx_r + 1'b1;
        s_ptr_r <= s_ptr_r + 1'b1;
        d_ptr_r <= d_ptr_r + 1'b1;
      end
    end
    out_read_data_r <= '0;
    out_pixels_r    <= '0;
    if (state_r == S_READ) begin
      out_read_data_r <= px;
    end
    if (state_r == S_DRAIN) begin
      out_pixels_r <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_pixels_written = out_pixels_r;

endmodule

`default_nettype wire
